FILE: rtl/core/gdfs_pkg.sv
// Shared types, constants and helpers for the graph depth-first path finder.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package gdfs_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VERTEX_WIDTH = $clog2(MAX_VERTICES);
   localparam int DEPTH_WIDTH  = $clog2(MAX_VERTICES + 1);
   localparam int COUNT_WIDTH  = 7;

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [VERTEX_WIDTH-1:0] vertex_type;

   typedef enum logic [1:0] {
      OP_ADD_EDGE  = 2'd0,
      OP_FIND_PATH = 2'd1,
      OP_CLEAR     = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_MISS  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] vertex_a;
      logic [5:0] vertex_b;
   } req_payload_type;

   typedef struct packed {
      logic [5:0] path_vertex;
      logic       found;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      cmd_kind_type kind;
      vertex_type   vertex_a;
      vertex_type   vertex_b;
   } cmd_type;

   function automatic row_type vertex_bit(input vertex_type v);
      vertex_bit = row_type'(1) << v;
   endfunction

   // Lowest set bit; zero when the row is empty.
   function automatic vertex_type find_first(input row_type row);
      vertex_type idx;
      idx = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (row[i]) idx = vertex_type'(i);
      end
      find_first = idx;
   endfunction

endpackage

FILE: rtl/core/gdfs_front.sv
// Front end: takes request transactions and classifies them into commands.
// Depends on gdfs_pkg; feeds gdfs_cmd_fifo.
`timescale 1ns / 1ps

module gdfs_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  gdfs_pkg::req_payload_type req_payload,
   input  gdfs_pkg::row_type         vertex_mask,
   input  logic                      fifo_full,
   output logic                      push,
   output gdfs_pkg::cmd_type         cmd
);
   import gdfs_pkg::*;

   logic in_range;

   assign req_ready = !fifo_full;
   assign in_range  = vertex_mask[req_payload.vertex_a] && vertex_mask[req_payload.vertex_b];

   always_comb begin
      cmd.vertex_a = req_payload.vertex_a;
      cmd.vertex_b = req_payload.vertex_b;
      cmd.kind     = CMD_CLEAR;
      push         = 1'b0;
      unique case (op_type'(req_payload.operation))
         OP_ADD_EDGE: begin
            // drop edges that touch a vertex beyond the count
            cmd.kind = CMD_ADD;
            push     = req_valid && in_range;
         end
         OP_FIND_PATH: begin
            cmd.kind = in_range ? CMD_QUERY : CMD_MISS;
            push     = req_valid;
         end
         OP_CLEAR: begin
            cmd.kind = CMD_CLEAR;
            push     = req_valid;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/core/gdfs_cmd_fifo.sv
// Two-entry command queue between the front end and the search engine.
// Depends on gdfs_pkg.
`timescale 1ns / 1ps

module gdfs_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gdfs_pkg::cmd_type push_cmd,
   input  logic              pop,
   output gdfs_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);
   import gdfs_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

FILE: rtl/core/gdfs_back.sv
// Search engine: holds the adjacency matrix and DFS stack, runs commands and
// drives the response register. Depends on gdfs_pkg.
`timescale 1ns / 1ps

module gdfs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fifo_empty,
   input  gdfs_pkg::cmd_type          head_cmd,
   output logic                       pop,
   input  gdfs_pkg::row_type          vertex_mask,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gdfs_pkg::rsp_payload_type  rsp_payload
);
   import gdfs_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ADD_A    = 9'b000000010,
      ST_ADD_B    = 9'b000000100,
      ST_Q_CHECK  = 9'b000001000,
      ST_Q_STEP   = 9'b000010000,
      ST_Q_POP    = 9'b000100000,
      ST_EMIT_RD  = 9'b001000000,
      ST_EMIT_OUT = 9'b010000000,
      ST_MISS     = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   vertex_type top_ff, top_in;
   vertex_type idx_ff, idx_in;
   logic [DEPTH_WIDTH-1:0] depth_ff, depth_in, depth_dec;
   row_type    visited_ff, visited_in;
   row_type    row_valid_ff, row_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // adjacency memory, one row per vertex
   row_type    adj_mem [MAX_VERTICES];
   row_type    adj_rd_data_ff;
   logic       adj_rd_valid_ff;
   logic       adj_rd_en, adj_wr_en;
   vertex_type adj_rd_addr, adj_wr_addr;
   row_type    adj_wr_data;

   // search stack memory
   vertex_type stk_mem [MAX_VERTICES];
   vertex_type stk_rd_data_ff;
   logic       stk_rd_en, stk_wr_en;
   vertex_type stk_rd_addr, stk_wr_addr, stk_wr_data;

   row_type    adj_row, cand;
   logic       out_free, emit_last;

   assign adj_row   = adj_rd_valid_ff ? adj_rd_data_ff : '0;
   assign cand      = adj_row & vertex_mask & ~visited_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign depth_dec = depth_ff - DEPTH_WIDTH'(1);
   assign emit_last = ({1'b0, idx_ff} + DEPTH_WIDTH'(1)) == depth_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      top_in         = top_ff;
      idx_in         = idx_ff;
      depth_in       = depth_ff;
      visited_in     = visited_ff;
      row_valid_in   = row_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      pop            = 1'b0;
      adj_rd_en      = 1'b0;
      adj_rd_addr    = top_ff;
      adj_wr_en      = 1'b0;
      adj_wr_addr    = cmd_ff.vertex_a;
      adj_wr_data    = adj_row;
      stk_rd_en      = 1'b0;
      stk_rd_addr    = idx_ff;
      stk_wr_en      = 1'b0;
      stk_wr_addr    = depth_ff[VERTEX_WIDTH-1:0];
      stk_wr_data    = head_cmd.vertex_a;

      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               unique case (head_cmd.kind)
                  CMD_ADD: begin
                     adj_rd_en   = 1'b1;
                     adj_rd_addr = head_cmd.vertex_a;
                     state_in    = ST_ADD_A;
                  end
                  CMD_CLEAR: begin
                     row_valid_in = '0;
                  end
                  CMD_QUERY: begin
                     stk_wr_en   = 1'b1;
                     stk_wr_addr = '0;
                     stk_wr_data = head_cmd.vertex_a;
                     depth_in    = DEPTH_WIDTH'(1);
                     top_in      = head_cmd.vertex_a;
                     visited_in  = vertex_bit(head_cmd.vertex_a);
                     state_in    = ST_Q_CHECK;
                  end
                  CMD_MISS: begin
                     state_in = ST_MISS;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD_A: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = cmd_ff.vertex_a;
            adj_wr_data = adj_row | vertex_bit(cmd_ff.vertex_b);
            row_valid_in[cmd_ff.vertex_a] = 1'b1;
            adj_rd_en   = 1'b1;
            adj_rd_addr = cmd_ff.vertex_b;
            state_in    = ST_ADD_B;
         end
         ST_ADD_B: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = cmd_ff.vertex_b;
            adj_wr_data = adj_row | vertex_bit(cmd_ff.vertex_a);
            row_valid_in[cmd_ff.vertex_b] = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_Q_CHECK: begin
            if (top_ff == cmd_ff.vertex_b) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               adj_rd_en   = 1'b1;
               adj_rd_addr = top_ff;
               state_in    = ST_Q_STEP;
            end
         end
         ST_Q_STEP: begin
            if (cand != '0) begin
               visited_in = visited_ff | vertex_bit(find_first(cand));
               if (depth_ff < DEPTH_WIDTH'(MAX_VERTICES)) begin
                  stk_wr_en   = 1'b1;
                  stk_wr_addr = depth_ff[VERTEX_WIDTH-1:0];
                  stk_wr_data = find_first(cand);
                  depth_in    = depth_ff + DEPTH_WIDTH'(1);
                  top_in      = find_first(cand);
               end
               state_in = ST_Q_CHECK;
            end else begin
               // dead end: drop the top and fetch the one below
               depth_in = depth_dec;
               if (depth_dec == '0) begin
                  state_in = ST_MISS;
               end else begin
                  stk_rd_en   = 1'b1;
                  stk_rd_addr = depth_dec[VERTEX_WIDTH-1:0] - VERTEX_WIDTH'(1);
                  state_in    = ST_Q_POP;
               end
            end
         end
         ST_Q_POP: begin
            top_in   = stk_rd_data_ff;
            state_in = ST_Q_CHECK;
         end
         ST_EMIT_RD: begin
            stk_rd_en   = 1'b1;
            stk_rd_addr = idx_ff;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.path_vertex = stk_rd_data_ff;
               rsp_payload_in.found       = 1'b1;
               rsp_payload_in.last        = emit_last;
               idx_in                     = idx_ff + VERTEX_WIDTH'(1);
               state_in                   = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_MISS: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.path_vertex = '0;
               rsp_payload_in.found       = 1'b0;
               rsp_payload_in.last        = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         visited_ff   <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         visited_ff   <= visited_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      top_ff         <= top_in;
      idx_ff         <= idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // capture the row valid bit with the data so a same-row write can't skew it
   always_ff @(posedge clock) begin
      if (adj_wr_en) adj_mem[adj_wr_addr] <= adj_wr_data;
      if (adj_rd_en) begin
         adj_rd_data_ff  <= adj_mem[adj_rd_addr];
         adj_rd_valid_ff <= row_valid_ff[adj_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_wr_en) stk_mem[stk_wr_addr] <= stk_wr_data;
      if (stk_rd_en) stk_rd_data_ff <= stk_mem[stk_rd_addr];
   end

endmodule

FILE: rtl/core/graph_dfs_path_finder.sv
// Top level of the graph depth-first path finder: vertex count register,
// front end, command queue and search engine. Depends on gdfs_pkg and the
// gdfs_front, gdfs_cmd_fifo and gdfs_back modules.
//
//   Channel  Direction  Handshake           Payload
//   req_     in         req_valid/ready     operation, vertex_a, vertex_b
//   rsp_     out        rsp_valid/ready     path_vertex, found, last
//   csr_     in         csr_wr_en           vertex_count (7 bits)
//
// Add edge reads and rewrites both adjacency rows; clear drops the row valid bits.
// A query's DFS push is an adjacency memory read, then find-first on the row; a
// pop adds a stack memory read of the new top; each path vertex emitted is a
// stack memory read, then a response. A held response stalls the engine in its
// emit or miss state; the two-entry command queue then fills and req_ready drops.
// Reset is synchronous, active high; the graph comes up empty via row valid bits.
`timescale 1ns / 1ps

module graph_dfs_path_finder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  gdfs_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gdfs_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [6:0]                 csr_wr_data
);
   import gdfs_pkg::*;

   row_type vertex_mask_ff, vertex_mask_in;
   cmd_type push_cmd, head_cmd;
   logic    push, pop, fifo_full, fifo_empty;

   // one bit per vertex below the programmed count
   always_comb begin
      vertex_mask_in = vertex_mask_ff;
      if (csr_wr_en) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            vertex_mask_in[i] = COUNT_WIDTH'(i) < csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_mask_ff <= '1;
      end else begin
         vertex_mask_ff <= vertex_mask_in;
      end
   end

   gdfs_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .vertex_mask (vertex_mask_ff),
      .fifo_full   (fifo_full),
      .push        (push),
      .cmd         (push_cmd)
   );

   gdfs_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   gdfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .vertex_mask (vertex_mask_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: bench/gdfs_path_checker.sv
// Checker for the graph depth-first path finder: predicts each query's path
// and compares every result transaction in order. Depends on gdfs_pkg.
`timescale 1ns / 1ps

module gdfs_path_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  gdfs_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  gdfs_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [6:0]                csr_wr_data,
   output int                        pending,
   output int                        errors
);
   import gdfs_pkg::*;

   row_type         graph_rows [MAX_VERTICES];
   logic [6:0]      count_reg;
   rsp_payload_type path_q [$];
   rsp_payload_type want;
   int              mism_count;

   task automatic note_mismatch(input string tag, input rsp_payload_type exp_item,
                                input rsp_payload_type got_item);
      mism_count++;
      if (mism_count <= 10)
         $display("%s: expected vertex %0d found %0b last %0b, got vertex %0d found %0b last %0b",
                  tag, exp_item.path_vertex, exp_item.found, exp_item.last,
                  got_item.path_vertex, got_item.found, got_item.last);
   endtask

   // Apply one request to the graph copy and queue the path it should produce.
   task automatic predict_item(input req_payload_type item);
      int         lim;
      int         depth;
      row_type    in_range;
      row_type    seen;
      row_type    cand;
      vertex_type stack_v [MAX_VERTICES];
      vertex_type nx;
      logic       hit;
      lim      = (count_reg > 7'd64) ? 64 : int'(count_reg);
      in_range = (lim >= 64) ? '1 : ((row_type'(1) << lim) - row_type'(1));
      case (item.operation)
         OP_CLEAR: begin
            foreach (graph_rows[i]) graph_rows[i] = '0;
         end
         OP_ADD_EDGE: begin
            if (item.vertex_a < lim && item.vertex_b < lim) begin
               graph_rows[item.vertex_a][item.vertex_b] = 1'b1;
               graph_rows[item.vertex_b][item.vertex_a] = 1'b1;
            end
         end
         OP_FIND_PATH: begin
            depth = 0;
            if (item.vertex_a < lim && item.vertex_b < lim) begin
               stack_v[0] = item.vertex_a;
               depth = 1;
               seen = '0;
               seen[item.vertex_a] = 1'b1;
               while (depth > 0 && stack_v[depth-1] != item.vertex_b) begin
                  cand = graph_rows[stack_v[depth-1]] & in_range & ~seen;
                  if (cand != '0) begin
                     // take the lowest-numbered unvisited neighbour
                     nx  = '0;
                     hit = 1'b0;
                     for (int i = 0; i < MAX_VERTICES; i++) begin
                        if (cand[i] && !hit) begin
                           nx  = vertex_type'(i);
                           hit = 1'b1;
                        end
                     end
                     seen[nx] = 1'b1;
                     if (depth < MAX_VERTICES) begin
                        stack_v[depth] = nx;
                        depth++;
                     end
                  end else begin
                     depth--;
                  end
               end
            end
            if (depth == 0) begin
               path_q.push_back(rsp_payload_type'({6'd0, 1'b0, 1'b1}));
            end else begin
               for (int i = 0; i < depth; i++)
                  path_q.push_back(rsp_payload_type'({stack_v[i], 1'b1, i == depth - 1}));
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (graph_rows[i]) graph_rows[i] = '0;
         count_reg  = 7'd64;
         mism_count = 0;
         path_q.delete();
      end else begin
         if (csr_wr_en) count_reg = csr_wr_data;
         if (req_valid && req_ready) predict_item(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (path_q.size() == 0) begin
               note_mismatch("result with nothing pending", '0, rsp_payload);
            end else begin
               want = path_q.pop_front();
               if (rsp_payload.path_vertex !== want.path_vertex ||
                   rsp_payload.found !== want.found || rsp_payload.last !== want.last)
                  note_mismatch("path mismatch", want, rsp_payload);
            end
         end
      end
      pending <= path_q.size();
      errors  <= mism_count;
   end

endmodule

FILE: bench/tb_graph_dfs_path_finder.sv
// Testbench top for the graph depth-first path finder: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on gdfs_pkg,
// graph_dfs_path_finder and gdfs_path_checker.
`timescale 1ns / 1ps

module tb_graph_dfs_path_finder;
   import gdfs_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         HOLD_CYCLES  = 800;
   localparam int         CYCLE_LIMIT  = 3000000;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic [6:0]      csr_wr_data = '0;

   int   pending;
   int   errors;
   int   cycle_count   = 0;
   int   cur_count     = 64;
   int   send_idle_pct = 36;
   int   rsp_idle_pct  = 58;
   logic hold_go       = 1'b0;
   logic hold_done     = 1'b0;
   int   hold_left     = 0;

   graph_dfs_path_finder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   gdfs_path_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .errors      (errors)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_graph_dfs_path_finder: FAIL");
         $finish;
      end
   end

   // Response back-pressure, with one long hold-off once requested.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic logic [5:0] pick_vertex(input int eff);
      if (eff == 0 || $urandom_range(99) < 8) return 6'($urandom_range(63));
      return 6'($urandom_range(eff - 1));
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [5:0] a, input logic [5:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req_payload_type'({op, a, b});
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait out every expected result, then let adds and clears settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_count(input logic [6:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_count = value;
   endtask

   // Mostly build a graph then query it; the rest is random noise.
   task automatic run_segment(input int quota);
      int sent;
      int eff;
      int v;
      sent = 0;
      while (sent < quota) begin
         eff = (cur_count > 64) ? 64 : cur_count;
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(2) == 0) begin
               send_item(OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)));
               sent++;
            end
            v = pick_vertex(eff);
            repeat ($urandom_range(1, 24)) begin
               // extend a chain so the search has long paths to walk
               if ($urandom_range(1) == 0 && eff > 1) begin
                  send_item(OP_ADD_EDGE, 6'(v), 6'((v + 1) % eff));
                  v = (v + 1) % eff;
               end else begin
                  send_item(OP_ADD_EDGE, pick_vertex(eff), pick_vertex(eff));
               end
               sent++;
            end
            repeat ($urandom_range(1, 6)) begin
               send_item(OP_FIND_PATH, pick_vertex(eff), pick_vertex(eff));
               sent++;
            end
         end else begin
            send_item(2'($urandom_range(3)), 6'($urandom_range(63)), 6'($urandom_range(63)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_count(7'd64);
      send_item(OP_CLEAR, 6'd0, 6'd0);
      send_item(OP_FIND_PATH, 6'd0, 6'd0);
      send_item(OP_FIND_PATH, 6'd0, 6'd63);
      send_item(OP_ADD_EDGE, 6'd0, 6'd63);
      send_item(OP_ADD_EDGE, 6'd63, 6'd63);
      send_item(OP_FIND_PATH, 6'd63, 6'd0);
      send_item(OP_FIND_PATH, 6'd63, 6'd63);
      send_item(OP_ADD_EDGE, 6'd1, 6'd2);
      send_item(OP_ADD_EDGE, 6'd2, 6'd3);
      send_item(OP_FIND_PATH, 6'd1, 6'd3);
      // dead-end branch through 6 must not appear in the path
      send_item(OP_ADD_EDGE, 6'd5, 6'd6);
      send_item(OP_ADD_EDGE, 6'd5, 6'd7);
      send_item(OP_ADD_EDGE, 6'd7, 6'd8);
      send_item(OP_FIND_PATH, 6'd5, 6'd8);
      send_item(OP_UNUSED, 6'd63, 6'd63);
      send_item(OP_ADD_EDGE, 6'd10, 6'd13);
      send_item(OP_ADD_EDGE, 6'd13, 6'd11);
      send_item(OP_FIND_PATH, 6'd10, 6'd11);
      // lowered count hides the detour through 13
      set_count(7'd12);
      send_item(OP_FIND_PATH, 6'd10, 6'd11);
      set_count(7'd127);
      send_item(OP_FIND_PATH, 6'd10, 6'd11);
      set_count(7'd0);
      send_item(OP_FIND_PATH, 6'd0, 6'd0);
      send_item(OP_ADD_EDGE, 6'd0, 6'd0);
      set_count(7'd1);
      send_item(OP_ADD_EDGE, 6'd0, 6'd0);
      send_item(OP_FIND_PATH, 6'd0, 6'd0);
      send_item(OP_FIND_PATH, 6'd0, 6'd1);

      set_count(7'd64);
      run_segment(35);
      set_count(7'd33);
      run_segment(30);

      send_idle_pct = 58;
      rsp_idle_pct <= 36;
      set_count(7'($urandom_range(3, 63)));
      run_segment(30);
      set_count(7'd2);
      run_segment(15);
      set_count(7'd127);
      run_segment(30);

      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      set_count(7'd48);
      hold_go <= 1'b1;
      run_segment(30);
      set_count(7'd64);
      run_segment(30);

      wait_drained();
      if (errors == 0) begin
         $display("tb_graph_dfs_path_finder: PASS");
      end else begin
         $display("tb_graph_dfs_path_finder: FAIL");
      end
      $finish;
   end

endmodule
